// ===== rtl/status_lamp_pattern_driver_defines.svh =====
// Assertion macros shared by the status lamp RTL.
`ifndef STATUS_LAMP_PATTERN_DRIVER_DEFINES_SVH
`define STATUS_LAMP_PATTERN_DRIVER_DEFINES_SVH

// Same-cycle implication.
`define SLPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slpd_pkg.sv =====
// Types, constants and pattern tables for the status lamp driver.
package slpd_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int OP_W           = 2;
  localparam int COUNT_W        = 8;
  localparam int DUR_W          = 16;
  localparam int NET_W          = 3;
  localparam int STREAK_W       = 8;
  localparam int PERIOD_W       = DUR_W + 1;
  localparam int PROD_W         = PERIOD_W + COUNT_W;
  localparam int PAT_W          = 3;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_BLIP  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLASH = 2'd2;

  localparam logic [DUR_W-1:0]    BLIP_DUR_RESET    = 16'd150;
  localparam logic [STREAK_W-1:0] AUTH_STREAK_LIMIT = 8'd5;

  localparam logic [NET_W-1:0] NET_UP           = 3'd0;
  localparam logic [NET_W-1:0] NET_SETUP_AP     = 3'd1;
  localparam logic [NET_W-1:0] NET_WIFI_RETRY   = 3'd2;
  localparam logic [NET_W-1:0] NET_REJOIN       = 3'd3;
  localparam logic [NET_W-1:0] NET_BROKER_RETRY = 3'd4;

  localparam logic [PAT_W-1:0] PAT_OFF          = 3'd0;
  localparam logic [PAT_W-1:0] PAT_FRESET       = 3'd1;
  localparam logic [PAT_W-1:0] PAT_SETUP_AP     = 3'd2;
  localparam logic [PAT_W-1:0] PAT_WIFI_AUTH    = 3'd3;
  localparam logic [PAT_W-1:0] PAT_WIFI_BACKOFF = 3'd4;
  localparam logic [PAT_W-1:0] PAT_LOGIN_PAGE   = 3'd5;
  localparam logic [PAT_W-1:0] PAT_BROKER_RETRY = 3'd6;
  localparam logic [PAT_W-1:0] PAT_JOINING      = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } slpd_div_stat_t;

  // Total length of one pattern cycle in ms.
  function automatic logic [PERIOD_W-1:0] pat_total(input logic [PAT_W-1:0] id);
    logic [PERIOD_W-1:0] tot;
    unique case (id)
      PAT_FRESET:       tot = PERIOD_W'(200);
      PAT_SETUP_AP:     tot = PERIOD_W'(1000);
      PAT_WIFI_AUTH:    tot = PERIOD_W'(2600);
      PAT_WIFI_BACKOFF: tot = PERIOD_W'(3000);
      PAT_LOGIN_PAGE:   tot = PERIOD_W'(3500);
      PAT_BROKER_RETRY: tot = PERIOD_W'(2900);
      PAT_JOINING:      tot = PERIOD_W'(1000);
      default:          tot = PERIOD_W'(200);
    endcase
    return tot;
  endfunction

  // Lamp level at offset t within a pattern cycle; segments start with on.
  function automatic logic pat_level(input logic [PAT_W-1:0] id,
                                     input logic [PERIOD_W-1:0] t);
    logic lvl;
    unique case (id)
      PAT_FRESET:       lvl = t < PERIOD_W'(100);
      PAT_SETUP_AP:     lvl = t < PERIOD_W'(500);
      PAT_WIFI_AUTH:    lvl = (t < PERIOD_W'(100)) ||
                              (t >= PERIOD_W'(250) && t < PERIOD_W'(350)) ||
                              (t >= PERIOD_W'(500) && t < PERIOD_W'(600));
      PAT_WIFI_BACKOFF: lvl = t < PERIOD_W'(100);
      PAT_LOGIN_PAGE:   lvl = (t < PERIOD_W'(500)) ||
                              (t >= PERIOD_W'(700) && t < PERIOD_W'(800)) ||
                              (t >= PERIOD_W'(1000) && t < PERIOD_W'(1500));
      PAT_BROKER_RETRY: lvl = (t < PERIOD_W'(100)) ||
                              (t >= PERIOD_W'(250) && t < PERIOD_W'(350));
      PAT_JOINING:      lvl = t < PERIOD_W'(100);
      default:          lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

// ===== rtl/slpd_channels.sv =====
// Valid/ready channel interfaces for lamp requests and results.
interface slpd_in_if import slpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [NOW_W-1:0]    now_ms;
  logic [COUNT_W-1:0]  flash_count;
  logic [DUR_W-1:0]    flash_on_ms;
  logic [DUR_W-1:0]    flash_off_ms;
  logic                logical_on;
  logic                factory_reset_wanted;
  logic [NET_W-1:0]    net_state;
  logic [STREAK_W-1:0] auth_fail_streak;
  logic                last_fail_captive;

  modport source (
    output valid, operation, now_ms, flash_count, flash_on_ms, flash_off_ms,
           logical_on, factory_reset_wanted, net_state, auth_fail_streak,
           last_fail_captive,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, flash_count, flash_on_ms, flash_off_ms,
           logical_on, factory_reset_wanted, net_state, auth_fail_streak,
           last_fail_captive,
    output ready
  );
endinterface

interface slpd_out_if import slpd_pkg::*; ();
  logic valid;
  logic ready;
  logic lamp_on;
  logic pin_changed;
  logic transient_active;

  modport source (output valid, lamp_on, pin_changed, transient_active, input ready);
  modport sink (input valid, lamp_on, pin_changed, transient_active, output ready);
endinterface

// ===== rtl/slpd_rem_serial.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`include "status_lamp_pattern_driver_defines.svh"

module slpd_rem_serial import slpd_pkg::*; #(
  parameter int X_W = TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [X_W-1:0]      dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output slpd_div_stat_t      stat,
  output logic [PERIOD_W-1:0] rem
);

  localparam int CNT_W = $clog2(X_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [X_W-1:0]      x_r;
  logic [PERIOD_W-1:0] r_r;
  logic [PERIOD_W-1:0] d_r;
  logic [PERIOD_W:0]   r2;
  logic [PERIOD_W-1:0] r_nxt;

  always_comb begin
    r2 = {r_r, x_r[X_W-1]};
    if (r2 >= {1'b0, d_r}) begin
      r_nxt = PERIOD_W'(r2 - {1'b0, d_r});
    end else begin
      r_nxt = r2[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(X_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      x_r <= x_r << 1;
      r_r <= r_nxt;
    end else if (start) begin
      x_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = r_r;

  `SLPD_ASSERT_NOW(a_rem_below_div, clk, rst_n, busy_r && d_r != '0, r_r < d_r, "remainder not below divisor")
  `SLPD_ASSERT_NEXT(a_last_step_done, clk, rst_n, busy_r && cnt_r == '0, done_r && !busy_r, "last step did not finish")
  `SLPD_ASSERT_NOW(a_done_idle, clk, rst_n, done_r, !busy_r, "done while still busy")

endmodule

// ===== rtl/status_lamp_pattern_driver.sv =====
// Top level of the status lamp pattern driver.
//
// Requests arrive on in_req (valid/ready): a tick, a blip command or a
// flash-sequence command with a millisecond timestamp. Each request gives
// exactly one result on out_req (valid/ready): lamp level, whether the pin
// changed, and whether a flash sequence or blip is still in progress.
// cfg_we/cfg_wdata write the blip duration in ms; write only while idle.
//
// A tick goes through ST_PREP, ST_CHECK and ST_DIV, where it waits on the
// serial remainder unit, which folds in one time bit per cycle; a command
// goes from ST_PREP straight to ST_OUT. One request is worked on at a
// time; in_req.ready rises again in the cycle the result is registered.
// The result sits in an output register; while the receiver stalls it is
// held, one more request may be taken and worked on, and its result then
// waits with in_req.ready low until the output register frees.
// Reset (rst_n low, synchronous) turns the lamp off, clears the flash
// sequence and blip deadline, and sets the blip duration to 150 ms.
module status_lamp_pattern_driver import slpd_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [DUR_W-1:0] cfg_wdata,
  slpd_in_if.sink          in_req,
  slpd_out_if.source       out_req
);

`include "status_lamp_pattern_driver_defines.svh"

  localparam int CMP_W = (TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]            state_r, state_nxt;

  logic [DUR_W-1:0]      blip_dur_r;
  logic                  pin_r;
  logic [TIME_WIDTH-1:0] blip_deadline_r;
  logic [COUNT_W-1:0]    flashes_left_r;
  logic [TIME_WIDTH-1:0] flash_start_r;
  logic [DUR_W-1:0]      flash_on_r;
  logic [PERIOD_W-1:0]   period_r;

  logic [OP_W-1:0]       op_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic                  logical_r;
  logic                  factory_r;
  logic [NET_W-1:0]      net_r;
  logic [STREAK_W-1:0]   streak_r;
  logic                  captive_r;

  logic                  blip_run_r;
  logic [TIME_WIDTH-1:0] elapsed_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  flash_live_r;
  logic [PAT_W-1:0]      pat_sel_r, pat_sel_nxt;
  logic                  lvl_r, lvl_nxt;
  logic                  pin_nxt;

  logic                  out_valid_r;
  logic                  out_lamp_r;
  logic                  out_changed_r;
  logic                  out_trans_r;

  logic                  in_fire;
  logic                  out_load;
  logic [TIME_WIDTH-1:0] now_in;
  logic [TIME_WIDTH-1:0] blip_diff;
  logic                  flash_go;
  logic [TIME_WIDTH-1:0] div_x;
  logic [PERIOD_W-1:0]   div_d;
  logic [PERIOD_W-1:0]   div_rem;
  slpd_div_stat_t        div_stat;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_load     = (state_r == ST_OUT) && (!out_valid_r || out_req.ready);
  assign now_in       = in_req.now_ms[TIME_WIDTH-1:0];
  assign blip_diff    = blip_deadline_r - now_r;

  assign flash_go = (flashes_left_r != '0) && (period_r != '0) &&
                    (CMP_W'(elapsed_r) < CMP_W'(prod_r));
  assign div_x    = flash_go ? elapsed_r : now_r;
  assign div_d    = flash_go ? period_r : pat_total(pat_sel_nxt);
  assign pin_nxt  = (op_r == OP_TICK) ? lvl_r : pin_r;

  always_comb begin
    if (factory_r) begin
      pat_sel_nxt = PAT_FRESET;
    end else begin
      case (net_r) inside
        NET_UP:                           pat_sel_nxt = PAT_OFF;
        NET_SETUP_AP:                     pat_sel_nxt = PAT_SETUP_AP;
        NET_WIFI_RETRY, NET_REJOIN:       pat_sel_nxt = (streak_r >= AUTH_STREAK_LIMIT) ?
                                                        PAT_WIFI_AUTH : PAT_WIFI_BACKOFF;
        NET_BROKER_RETRY:                 pat_sel_nxt = captive_r ?
                                                        PAT_LOGIN_PAGE : PAT_BROKER_RETRY;
        default:                          pat_sel_nxt = PAT_JOINING;
      endcase
    end
  end

  always_comb begin
    if (flash_live_r) begin
      lvl_nxt = div_rem < PERIOD_W'(flash_on_r);
    end else if (blip_run_r) begin
      lvl_nxt = !logical_r;
    end else if (logical_r) begin
      lvl_nxt = 1'b1;
    end else begin
      lvl_nxt = pat_level(pat_sel_r, div_rem);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = (op_r == OP_TICK) ? ST_CHECK : ST_OUT;
      ST_CHECK: state_nxt = ST_DIV;
      ST_DIV:   if (div_stat.done) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      blip_dur_r      <= BLIP_DUR_RESET;
      pin_r           <= 1'b0;
      blip_deadline_r <= '0;
      flashes_left_r  <= '0;
      flash_start_r   <= '0;
      flash_on_r      <= '0;
      period_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) blip_dur_r <= cfg_wdata;
      if (in_fire && in_req.operation == OP_BLIP) begin
        blip_deadline_r <= now_in + TIME_WIDTH'(blip_dur_r);
      end
      if (in_fire && in_req.operation == OP_FLASH) begin
        flashes_left_r <= in_req.flash_count;
        flash_on_r     <= in_req.flash_on_ms;
        period_r       <= PERIOD_W'(in_req.flash_on_ms) + PERIOD_W'(in_req.flash_off_ms);
        flash_start_r  <= now_in;
      end
      if (state_r == ST_CHECK && !flash_go) flashes_left_r <= '0;
      out_valid_r <= out_load || (out_valid_r && !out_req.ready);
      if (out_load) pin_r <= pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= in_req.operation;
      now_r     <= now_in;
      logical_r <= in_req.logical_on;
      factory_r <= in_req.factory_reset_wanted;
      net_r     <= in_req.net_state;
      streak_r  <= in_req.auth_fail_streak;
      captive_r <= in_req.last_fail_captive;
    end
    if (state_r == ST_PREP) begin
      blip_run_r <= (blip_diff != '0) && !blip_diff[TIME_WIDTH-1];
      elapsed_r  <= now_r - flash_start_r;
      prod_r     <= PROD_W'(period_r) * PROD_W'(flashes_left_r);
    end
    if (state_r == ST_CHECK) begin
      flash_live_r <= flash_go;
      pat_sel_r    <= pat_sel_nxt;
    end
    if (state_r == ST_DIV && div_stat.done) lvl_r <= lvl_nxt;
    if (out_load) begin
      out_lamp_r    <= pin_nxt;
      out_changed_r <= pin_nxt != pin_r;
      out_trans_r   <= (flashes_left_r != '0) || blip_run_r;
    end
  end

  slpd_rem_serial #(
    .X_W (TIME_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_CHECK),
    .dividend (div_x),
    .divisor  (div_d),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  assign out_req.valid            = out_valid_r;
  assign out_req.lamp_on          = out_lamp_r;
  assign out_req.pin_changed      = out_changed_r;
  assign out_req.transient_active = out_trans_r;

  `SLPD_ASSERT_NOW(a_div_running, clk, rst_n, state_r == ST_DIV,
                   div_stat.busy || div_stat.done, "waiting on idle divider")
  `SLPD_ASSERT_NEXT(a_cmd_keeps_pin, clk, rst_n, out_load && op_r != OP_TICK,
                    !out_changed_r && $stable(pin_r), "command moved the pin")
  `SLPD_ASSERT_NOW(a_flash_live_state, clk, rst_n, state_r == ST_DIV && flash_live_r,
                   flashes_left_r != '0 && period_r != '0, "flash phase without sequence")

endmodule

// ===== bench/status_lamp_pattern_driver_test.sv =====
// Self-checking bench for the status lamp pattern driver: directed and random requests.
`timescale 1ns / 1ps

module status_lamp_pattern_driver_test;
  import slpd_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED      = 2'd3;
  localparam logic [NET_W-1:0] NET_CONNECTING = 3'd7;

  typedef struct {
    logic [OP_W-1:0]     operation;
    logic [NOW_W-1:0]    now_ms;
    logic [COUNT_W-1:0]  flash_count;
    logic [DUR_W-1:0]    flash_on_ms;
    logic [DUR_W-1:0]    flash_off_ms;
    logic                logical_on;
    logic                factory_reset_wanted;
    logic [NET_W-1:0]    net_state;
    logic [STREAK_W-1:0] auth_fail_streak;
    logic                last_fail_captive;
  } lamp_req_t;

  typedef struct {
    logic lamp_on;
    logic pin_changed;
    logic transient_active;
  } lamp_res_t;

  class lamp_scoreboard;
    logic [DUR_W-1:0]   blip_length;
    logic               pin_level;
    logic [NOW_W-1:0]   blip_deadline;
    logic [COUNT_W-1:0] flashes_left;
    logic [NOW_W-1:0]   flash_start;
    logic [DUR_W-1:0]   flash_on;
    logic [DUR_W-1:0]   flash_off;
    lamp_res_t          expected_levels[$];
    int unsigned        failures;
    int unsigned        op_seen[4];

    function new();
      blip_length   = BLIP_DUR_RESET;
      pin_level     = 1'b0;
      blip_deadline = '0;
      flashes_left  = '0;
      flash_start   = '0;
      flash_on      = '0;
      flash_off     = '0;
      failures      = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function logic blip_active(logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] diff;
      diff = blip_deadline - now;
      return diff != '0 && !diff[NOW_W-1];
    endfunction

    // Segments alternate on/off starting with on; zero entries pad the table.
    function logic pattern_level(logic [PAT_W-1:0] id, logic [NOW_W-1:0] now);
      int unsigned seg[6];
      int unsigned total;
      int unsigned t;
      case (id)
        PAT_FRESET:       seg = '{100, 100, 0, 0, 0, 0};
        PAT_SETUP_AP:     seg = '{500, 500, 0, 0, 0, 0};
        PAT_WIFI_AUTH:    seg = '{100, 150, 100, 150, 100, 2000};
        PAT_WIFI_BACKOFF: seg = '{100, 2900, 0, 0, 0, 0};
        PAT_LOGIN_PAGE:   seg = '{500, 200, 100, 200, 500, 2000};
        PAT_BROKER_RETRY: seg = '{100, 150, 100, 2550, 0, 0};
        default:          seg = '{100, 900, 0, 0, 0, 0};
      endcase
      total = 0;
      foreach (seg[i]) total += seg[i];
      t = now % total;
      foreach (seg[i]) begin
        if (t < seg[i]) return (i % 2) == 0;
        t -= seg[i];
      end
      return 1'b0;
    endfunction

    function logic tick_level(lamp_req_t r);
      logic [DUR_W:0]   period;
      logic [NOW_W-1:0] elapsed;
      logic [NOW_W-1:0] offset;
      logic             lvl;
      if (flashes_left != 0) begin
        period  = {1'b0, flash_on} + {1'b0, flash_off};
        elapsed = r.now_ms - flash_start;
        if (period == 0 || 64'(elapsed) >= 64'(period) * 64'(flashes_left)) begin
          flashes_left = '0;
        end else begin
          offset = elapsed % period;
          return offset < flash_on;
        end
      end
      if (blip_active(r.now_ms)) return !r.logical_on;
      if (r.logical_on) return 1'b1;
      if (r.factory_reset_wanted) return pattern_level(PAT_FRESET, r.now_ms);
      case (r.net_state)
        NET_UP: lvl = 1'b0;
        NET_SETUP_AP: lvl = pattern_level(PAT_SETUP_AP, r.now_ms);
        NET_WIFI_RETRY, NET_REJOIN: begin
          lvl = pattern_level(r.auth_fail_streak >= AUTH_STREAK_LIMIT ?
                              PAT_WIFI_AUTH : PAT_WIFI_BACKOFF, r.now_ms);
        end
        NET_BROKER_RETRY: begin
          lvl = pattern_level(r.last_fail_captive ? PAT_LOGIN_PAGE : PAT_BROKER_RETRY,
                              r.now_ms);
        end
        default: lvl = pattern_level(PAT_JOINING, r.now_ms);
      endcase
      return lvl;
    endfunction

    function void note_request(lamp_req_t r);
      lamp_res_t res;
      logic      prev;
      prev = pin_level;
      op_seen[r.operation]++;
      case (r.operation)
        OP_TICK:  pin_level = tick_level(r);
        OP_BLIP:  blip_deadline = r.now_ms + blip_length;
        OP_FLASH: begin
          flashes_left = r.flash_count;
          flash_on     = r.flash_on_ms;
          flash_off    = r.flash_off_ms;
          flash_start  = r.now_ms;
        end
        default: ;
      endcase
      res.lamp_on          = pin_level;
      res.pin_changed      = pin_level != prev;
      res.transient_active = flashes_left != 0 || blip_active(r.now_ms);
      expected_levels.push_back(res);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(lamp_res_t got);
      lamp_res_t want;
      if (expected_levels.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %0b/%0b/%0b",
                 $time, got.lamp_on, got.pin_changed, got.transient_active);
        failures++;
        return;
      end
      want = expected_levels.pop_front();
      compare_field("lamp_on", want.lamp_on, got.lamp_on);
      compare_field("pin_changed", want.pin_changed, got.pin_changed);
      compare_field("transient_active", want.transient_active, got.transient_active);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [DUR_W-1:0] cfg_wdata;
  bit               idle_on = 1'b1;
  logic [NOW_W-1:0] clock_ms;
  int unsigned      cfg_writes = 0;

  slpd_in_if  in_ch ();
  slpd_out_if out_ch ();
  lamp_scoreboard sb = new();

  status_lamp_pattern_driver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_ch),
    .out_req   (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    lamp_req_t acc;
    lamp_res_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.lamp_on          = out_ch.lamp_on;
        got.pin_changed      = out_ch.pin_changed;
        got.transient_active = out_ch.transient_active;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        acc.operation            = in_ch.operation;
        acc.now_ms               = in_ch.now_ms;
        acc.flash_count          = in_ch.flash_count;
        acc.flash_on_ms          = in_ch.flash_on_ms;
        acc.flash_off_ms         = in_ch.flash_off_ms;
        acc.logical_on           = in_ch.logical_on;
        acc.factory_reset_wanted = in_ch.factory_reset_wanted;
        acc.net_state            = in_ch.net_state;
        acc.auth_fail_streak     = in_ch.auth_fail_streak;
        acc.last_fail_captive    = in_ch.last_fail_captive;
        sb.note_request(acc);
      end
    end
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  initial begin
    int unsigned hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      hold = idle_cycles();
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  function automatic lamp_req_t any_request();
    lamp_req_t r;
    r.operation            = OP_W'($urandom_range(0, 3));
    r.now_ms               = $urandom();
    r.flash_count          = COUNT_W'($urandom_range(0, 255));
    r.flash_on_ms          = DUR_W'($urandom_range(0, 65535));
    r.flash_off_ms         = DUR_W'($urandom_range(0, 65535));
    r.logical_on           = 1'($urandom_range(0, 1));
    r.factory_reset_wanted = 1'($urandom_range(0, 1));
    r.net_state            = NET_W'($urandom_range(0, 7));
    r.auth_fail_streak     = STREAK_W'($urandom_range(0, 255));
    r.last_fail_captive    = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic lamp_req_t tick_at(logic [NOW_W-1:0] now, logic lon, logic factory,
                                        logic [NET_W-1:0] net, logic [STREAK_W-1:0] streak,
                                        logic captive);
    lamp_req_t r;
    r                      = any_request();
    r.operation            = OP_TICK;
    r.now_ms               = now;
    r.logical_on           = lon;
    r.factory_reset_wanted = factory;
    r.net_state            = net;
    r.auth_fail_streak     = streak;
    r.last_fail_captive    = captive;
    return r;
  endfunction

  function automatic lamp_req_t command_at(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
                                           logic [COUNT_W-1:0] count,
                                           logic [DUR_W-1:0] on_ms, logic [DUR_W-1:0] off_ms);
    lamp_req_t r;
    r              = any_request();
    r.operation    = op;
    r.now_ms       = now;
    r.flash_count  = count;
    r.flash_on_ms  = on_ms;
    r.flash_off_ms = off_ms;
    return r;
  endfunction

  task automatic send_request(lamp_req_t r);
    int unsigned gap;
    in_ch.valid                <= 1'b1;
    in_ch.operation            <= r.operation;
    in_ch.now_ms               <= r.now_ms;
    in_ch.flash_count          <= r.flash_count;
    in_ch.flash_on_ms          <= r.flash_on_ms;
    in_ch.flash_off_ms         <= r.flash_off_ms;
    in_ch.logical_on           <= r.logical_on;
    in_ch.factory_reset_wanted <= r.factory_reset_wanted;
    in_ch.net_state            <= r.net_state;
    in_ch.auth_fail_streak     <= r.auth_fail_streak;
    in_ch.last_fail_captive    <= r.last_fail_captive;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gap = idle_cycles();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Checked on falling edges so the monitor has already run for the cycle.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_levels.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_blip_length(logic [DUR_W-1:0] ms);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.blip_length = ms;
    cfg_writes++;
  endtask

  task automatic run_directed();
    send_request(tick_at(32'd0, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd1, 1'b1, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd50, 1'b0, 1'b1, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd150, 1'b0, 1'b1, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd400, 1'b0, 1'b0, NET_SETUP_AP, 8'd0, 1'b0));
    send_request(tick_at(32'd700, 1'b0, 1'b0, NET_SETUP_AP, 8'd0, 1'b0));
    send_request(tick_at(32'd3050, 1'b0, 1'b0, NET_WIFI_RETRY, 8'd4, 1'b0));
    send_request(tick_at(32'd2860, 1'b0, 1'b0, NET_REJOIN, AUTH_STREAK_LIMIT, 1'b0));
    send_request(tick_at(32'd300, 1'b0, 1'b0, NET_BROKER_RETRY, 8'hFF, 1'b0));
    send_request(tick_at(32'd750, 1'b0, 1'b0, NET_BROKER_RETRY, 8'd0, 1'b1));
    send_request(tick_at(32'hFFFF_FFFF, 1'b0, 1'b0, NET_CONNECTING, 8'd0, 1'b1));
    // blip inverts the logical state until its deadline
    send_request(command_at(OP_BLIP, 32'd1000, 8'd0, 16'd0, 16'd0));
    send_request(tick_at(32'd1000, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd1149, 1'b1, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd1150, 1'b1, 1'b0, NET_UP, 8'd0, 1'b0));
    // zero count, normal sequence, zero period
    send_request(command_at(OP_FLASH, 32'd2000, 8'd0, 16'd10, 16'd10));
    send_request(command_at(OP_FLASH, 32'd2000, 8'd3, 16'd10, 16'd10));
    send_request(tick_at(32'd2005, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd2015, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(tick_at(32'd2060, 1'b1, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(command_at(OP_FLASH, 32'd2100, 8'd5, 16'd0, 16'd0));
    send_request(tick_at(32'd2100, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
    // longest sequence across the wrap, then ended by a far jump
    send_request(command_at(OP_FLASH, 32'hFFFF_FF00, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_request(tick_at(32'h0000_0010, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(command_at(OP_UNUSED, 32'h0000_0020, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_request(tick_at(32'h8000_0000, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
    send_request(command_at(OP_BLIP, 32'hFFFF_FFF0, 8'd0, 16'd0, 16'd0));
    send_request(tick_at(32'h0000_0005, 1'b0, 1'b0, NET_UP, 8'd0, 1'b0));
  endtask

  // Mostly a command followed by a sweep of ticks through it; some noise.
  task automatic run_sequences(int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned step_max;
    lamp_req_t   r;
    lamp_req_t   ctx;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        case ($urandom_range(0, 3))
          0:       clock_ms = $urandom();
          1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
          default: clock_ms = clock_ms + $urandom_range(1, 5000);
        endcase
        ctx = tick_at(clock_ms, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0,
                      NET_W'($urandom_range(0, 7)),
                      STREAK_W'($urandom_range(0, 1) ? $urandom_range(0, 9) :
                                                       $urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        r = any_request();
        r.now_ms = clock_ms;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          r.operation = OP_FLASH;
          if ($urandom_range(0, 7) != 0) begin
            r.flash_count  = COUNT_W'($urandom_range(1, 6));
            r.flash_on_ms  = DUR_W'($urandom_range(0, 300));
            r.flash_off_ms = DUR_W'($urandom_range(0, 300));
          end
        end else if (kind < 7) begin
          r.operation = OP_BLIP;
        end
        if (kind < 7) begin
          send_request(r);
          sent++;
        end
        step_max = $urandom_range(1, 200);
        repeat ($urandom_range(4, 16)) begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          ctx.now_ms = clock_ms;
          if ($urandom_range(0, 7) == 0) ctx.logical_on = !ctx.logical_on;
          if ($urandom_range(0, 9) == 0) ctx.net_state = NET_W'($urandom_range(0, 7));
          send_request(ctx);
          sent++;
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4)) begin
          send_request(any_request());
          sent++;
        end
      end else begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    rst_n                      <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_wdata                  <= '0;
    in_ch.valid                <= 1'b0;
    in_ch.operation            <= OP_TICK;
    in_ch.now_ms               <= '0;
    in_ch.flash_count          <= '0;
    in_ch.flash_on_ms          <= '0;
    in_ch.flash_off_ms         <= '0;
    in_ch.logical_on           <= 1'b0;
    in_ch.factory_reset_wanted <= 1'b0;
    in_ch.net_state            <= NET_UP;
    in_ch.auth_fail_streak     <= '0;
    in_ch.last_fail_captive    <= 1'b0;
    clock_ms = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    set_blip_length(16'd1);
    run_sequences(125);
    idle_on = 1'b0;
    set_blip_length(16'hFFFF);
    run_sequences(125);
    idle_on = 1'b1;
    set_blip_length(DUR_W'($urandom_range(2, 2000)));
    run_sequences(125);
    set_blip_length(BLIP_DUR_RESET);
    run_sequences(120);

    wait_results_drained();
    repeat (50) @(posedge clk);
    $display("Run covered %0d ticks, %0d blip and %0d flash commands, %0d unused-code requests",
             sb.op_seen[OP_TICK], sb.op_seen[OP_BLIP], sb.op_seen[OP_FLASH],
             sb.op_seen[OP_UNUSED]);
    $display("across %0d blip-length writes, from 1 ms up to 65535 ms", cfg_writes);
    if (sb.failures == 0 && sb.expected_levels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== status_lamp_pattern_driver.f =====
+incdir+rtl
rtl/slpd_pkg.sv
rtl/slpd_channels.sv
rtl/slpd_rem_serial.sv
rtl/status_lamp_pattern_driver.sv
bench/status_lamp_pattern_driver_test.sv
